// File: src/pdtp_pkg.sv
// ----------------------------------------------------------------------------
// pdtp_pkg
// Types and constants shared by the date/time pattern parser modules.
// ----------------------------------------------------------------------------
package pdtp_pkg;

    // Number of pattern codes the parser can walk through
    localparam int          C_MAX_CODES = 16;
    localparam logic [4:0]  C_MAX_LEN   = 5'(C_MAX_CODES);

    // Pattern codes
    localparam logic [3:0] C_CODE_SKIP       = 4'd0;
    localparam logic [3:0] C_CODE_YY         = 4'd1;
    localparam logic [3:0] C_CODE_YYYY       = 4'd2;
    localparam logic [3:0] C_CODE_MONTH_FLEX = 4'd3;
    localparam logic [3:0] C_CODE_MONTH      = 4'd4;
    localparam logic [3:0] C_CODE_DAY_FLEX   = 4'd5;
    localparam logic [3:0] C_CODE_DAY        = 4'd6;
    localparam logic [3:0] C_CODE_HOUR       = 4'd7;
    localparam logic [3:0] C_CODE_MINUTE     = 4'd8;
    localparam logic [3:0] C_CODE_SECOND     = 4'd9;

    // Configuration register indexes
    localparam logic [0:0] C_REG_PATTERN_CODES  = 1'b0;
    localparam logic [0:0] C_REG_PATTERN_LENGTH = 1'b1;

    localparam logic [13:0] C_YEAR_BASE   = 14'd1900;
    // year / 100 == (year * 5243) >> 19 for every 14-bit year
    localparam logic [12:0] C_RECIP_100   = 13'd5243;
    localparam int          C_RECIP_SHIFT = 19;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [13:0] year_value;
        logic [6:0]  month_value;
        logic [6:0]  day_value;
        logic [6:0]  hour_value;
        logic [6:0]  minute_value;
        logic [6:0]  second_value;
        logic        pattern_matched;
        logic        date_time_valid;
    } t_out_item;

    // Parsed fields before the calendar check
    typedef struct packed {
        logic [13:0] year_value;
        logic [6:0]  month_value;
        logic [6:0]  day_value;
        logic [6:0]  hour_value;
        logic [6:0]  minute_value;
        logic [6:0]  second_value;
        logic        pattern_matched;
    } t_fields;

    typedef struct packed {
        logic [4:0]  idx;
        logic [2:0]  digits;
        logic [13:0] acc;
        logic        bad;
        logic        failed;
        logic [13:0] year;
        logic [6:0]  month;
        logic [6:0]  day;
        logic [6:0]  hour;
        logic [6:0]  minute;
        logic [6:0]  second;
    } t_parse_state;

    typedef struct packed {
        t_parse_state st;
        logic         again;
    } t_step_res;

    function automatic logic [4:0] days_in_month(input logic [6:0] month, input logic leap);
        logic [4:0] days;
        case (month)
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: days = 5'd31;
            7'd4, 7'd6, 7'd9, 7'd11:                     days = 5'd30;
            7'd2:                                        days = leap ? 5'd29 : 5'd28;
            default:                                     days = 5'd0;
        endcase
        return days;
    endfunction

endpackage

// File: src/pdtp_parse.sv
// ----------------------------------------------------------------------------
// pdtp_parse
// Per-character parse state. Consumes one character per step, resolving up
// to two pattern codes, and forms the parsed fields on the last character.
// ----------------------------------------------------------------------------
module pdtp_parse (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [7:0]        i_char,
    input  logic              i_last,
    input  logic [63:0]       i_codes,
    input  logic [4:0]        i_length,
    output pdtp_pkg::t_fields o_fields
);

    pdtp_pkg::t_parse_state r_state;
    pdtp_pkg::t_parse_state n_state;
    pdtp_pkg::t_parse_state fin;
    pdtp_pkg::t_step_res    pass1;
    pdtp_pkg::t_step_res    pass2;
    logic [4:0]             used_len;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [3:0]             fin_code;
    logic                   pending;
    logic                   matched;

    function automatic logic [3:0] code_at(input logic [63:0] codes, input logic [4:0] idx);
        return codes[{idx[3:0], 2'b00} +: 4];
    endfunction

    function automatic pdtp_pkg::t_parse_state commit(
        input pdtp_pkg::t_parse_state s,
        input logic [3:0]             code
    );
        pdtp_pkg::t_parse_state r;
        logic [13:0]            v;
        r = s;
        v = s.bad ? 14'd0 : s.acc;
        case (code)
            pdtp_pkg::C_CODE_YY:   r.year = 14'(pdtp_pkg::C_YEAR_BASE + v);
            pdtp_pkg::C_CODE_YYYY: r.year = v;
            pdtp_pkg::C_CODE_MONTH_FLEX,
            pdtp_pkg::C_CODE_MONTH:  r.month = v[6:0];
            pdtp_pkg::C_CODE_DAY_FLEX,
            pdtp_pkg::C_CODE_DAY:    r.day = v[6:0];
            pdtp_pkg::C_CODE_HOUR:   r.hour = v[6:0];
            pdtp_pkg::C_CODE_MINUTE: r.minute = v[6:0];
            pdtp_pkg::C_CODE_SECOND: r.second = v[6:0];
            default: ;
        endcase
        r.acc    = 14'd0;
        r.bad    = 1'b0;
        r.digits = 3'd0;
        r.idx    = 5'(s.idx + 5'd1);
        return r;
    endfunction

    // Resolve one pattern code against the current character. again is set
    // when a flexible field ends on a non-digit that the next code must see.
    function automatic pdtp_pkg::t_step_res step_once(
        input pdtp_pkg::t_parse_state s,
        input logic [63:0]            codes,
        input logic [4:0]             len,
        input logic                   dig,
        input logic [3:0]             d
    );
        pdtp_pkg::t_step_res r;
        logic [3:0]          code;
        logic [2:0]          width;
        r.st    = s;
        r.again = 1'b0;
        code    = code_at(codes, s.idx);
        width   = (code == pdtp_pkg::C_CODE_YYYY) ? 3'd4 : 3'd2;
        if (!s.failed && s.idx < len) begin
            if (!(code inside {[pdtp_pkg::C_CODE_YY:pdtp_pkg::C_CODE_SECOND]})) begin
                r.st.idx = 5'(s.idx + 5'd1);
            end else if (code == pdtp_pkg::C_CODE_MONTH_FLEX ||
                         code == pdtp_pkg::C_CODE_DAY_FLEX) begin
                if (s.digits == 3'd0) begin
                    if (dig) begin
                        r.st.acc    = 14'(d);
                        r.st.digits = 3'd1;
                    end else begin
                        r.st.failed = 1'b1;
                    end
                end else if (dig) begin
                    r.st.acc = 14'(s.acc * 14'd10 + 14'(d));
                    r.st     = commit(r.st, code);
                end else begin
                    r.st    = commit(s, code);
                    r.again = 1'b1;
                end
            end else begin
                if (dig) begin
                    r.st.acc = 14'(s.acc * 14'd10 + 14'(d));
                end else begin
                    r.st.bad = 1'b1;
                end
                r.st.digits = 3'(s.digits + 3'd1);
                if (r.st.digits >= width) begin
                    r.st = commit(r.st, code);
                end
            end
        end
        return r;
    endfunction

    always_comb begin
        used_len = (i_length > pdtp_pkg::C_MAX_LEN) ? pdtp_pkg::C_MAX_LEN : i_length;
        is_digit = i_char inside {[8'd48:8'd57]};
        digit    = is_digit ? i_char[3:0] : 4'd0;

        pass1 = step_once(r_state, i_codes, used_len, is_digit, digit);
        pass2 = pass1.again ? step_once(pass1.st, i_codes, used_len, is_digit, digit) : pass1;

        // End of string: close a one-digit flexible field still open
        fin      = pass2.st;
        fin_code = code_at(i_codes, fin.idx);
        if (!fin.failed && fin.idx < used_len && fin.digits == 3'd1 &&
            (fin_code == pdtp_pkg::C_CODE_MONTH_FLEX ||
             fin_code == pdtp_pkg::C_CODE_DAY_FLEX)) begin
            fin = commit(fin, fin_code);
        end

        // Any field code left unparsed fails the match
        pending = 1'b0;
        for (int i = 0; i < pdtp_pkg::C_MAX_CODES; i++) begin
            if (5'(i) >= fin.idx && 5'(i) < used_len &&
                i_codes[4*i +: 4] inside {[pdtp_pkg::C_CODE_YY:pdtp_pkg::C_CODE_SECOND]}) begin
                pending = 1'b1;
            end
        end
        matched = !fin.failed && !pending;

        o_fields.pattern_matched = matched;
        o_fields.year_value      = matched ? fin.year   : 14'd0;
        o_fields.month_value     = matched ? fin.month  : 7'd0;
        o_fields.day_value       = matched ? fin.day    : 7'd0;
        o_fields.hour_value      = matched ? fin.hour   : 7'd0;
        o_fields.minute_value    = matched ? fin.minute : 7'd0;
        o_fields.second_value    = matched ? fin.second : 7'd0;

        n_state = i_last ? '0 : pass2.st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_step) begin
            r_state <= n_state;
        end
    end

endmodule

// File: src/pdtp_calendar.sv
// ----------------------------------------------------------------------------
// pdtp_calendar
// Two-stage calendar check: year / 100 by reciprocal multiply, then leap
// year, days in month and time ranges into the result register.
// ----------------------------------------------------------------------------
module pdtp_calendar (
    input  logic                i_clk,
    input  logic                i_load_s2,
    input  logic                i_load_s3,
    input  pdtp_pkg::t_fields   i_fields,
    output pdtp_pkg::t_out_item o_item
);

    pdtp_pkg::t_fields   r_s2_fields;
    logic [7:0]          r_s2_quot;
    pdtp_pkg::t_out_item r_s3_item;

    pdtp_pkg::t_fields   s2_f;
    pdtp_pkg::t_out_item n_s3_item;
    logic [26:0]         n_prod;
    logic [7:0]          n_quot;
    logic [13:0]         rem_100;
    logic                leap;
    logic [4:0]          dim;
    logic                valid;

    always_comb begin
        n_prod = 27'(i_fields.year_value) * 27'(pdtp_pkg::C_RECIP_100);
        n_quot = 8'(n_prod >> pdtp_pkg::C_RECIP_SHIFT);
    end

    always_comb begin
        s2_f    = r_s2_fields;
        rem_100 = 14'(s2_f.year_value - 14'(14'(r_s2_quot) * 14'd100));
        // divisible by 400 == divisible by 100 with quotient divisible by 4
        leap    = (s2_f.year_value[1:0] == 2'd0) &&
                  (rem_100 != 14'd0 || r_s2_quot[1:0] == 2'd0);
        dim     = pdtp_pkg::days_in_month(s2_f.month_value, leap);
        valid   = s2_f.pattern_matched && s2_f.year_value != 14'd0 && dim != 5'd0 &&
                  s2_f.day_value >= 7'd1 && s2_f.day_value <= 7'(dim) &&
                  s2_f.hour_value < 7'd24 && s2_f.minute_value < 7'd60 &&
                  s2_f.second_value < 7'd60;

        n_s3_item.year_value      = s2_f.year_value;
        n_s3_item.month_value     = s2_f.month_value;
        n_s3_item.day_value       = s2_f.day_value;
        n_s3_item.hour_value      = s2_f.hour_value;
        n_s3_item.minute_value    = s2_f.minute_value;
        n_s3_item.second_value    = s2_f.second_value;
        n_s3_item.pattern_matched = s2_f.pattern_matched;
        n_s3_item.date_time_valid = valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_load_s2) begin
            r_s2_fields <= i_fields;
            r_s2_quot   <= n_quot;
        end
        if (i_load_s3) begin
            r_s3_item <= n_s3_item;
        end
    end

    assign o_item = r_s3_item;

endmodule

// File: src/pattern_date_time_parser_top.sv
// ----------------------------------------------------------------------------
// pattern_date_time_parser_top
// Pattern-driven date/time string parser: one character per transaction,
// one result transaction on each character marked last.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                  Payload
//  input    in         i_in_valid / o_in_stall    i_in_data  (t_in_item)
//  output   out        o_out_valid / i_out_stall  o_out_data (t_out_item)
//  config   in         i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
//  One character is taken every cycle unless a last character meets a stall;
//  the parse state loop runs only through the parse state and the parse logic.
//  After its last character is taken, a result is formed by parse, then
//  reciprocal multiply for year / 100, then calendar check into the result register.
//  Reset is synchronous and clears parse state, configuration and all valids.
//  A stall passes back in the same cycle through every full stage; characters
//  that close no string keep flowing while a result waits at the output.
// ----------------------------------------------------------------------------
module pattern_date_time_parser_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  pdtp_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output pdtp_pkg::t_out_item o_out_data,
    input  logic                i_cfg_wr_en,
    input  logic [0:0]          i_cfg_index,
    input  logic [63:0]         i_cfg_wdata
);

    logic [63:0]        r_pattern_codes;
    logic [4:0]         r_pattern_length;
    pdtp_pkg::t_in_item r_s0;
    pdtp_pkg::t_fields  r_s1;
    logic               r_v0, r_v1, r_v2, r_v3;

    pdtp_pkg::t_fields  parse_fields;
    logic               rdy0, rdy1, rdy2, rdy3;
    logic               adv0;

    always_comb begin
        rdy3 = !r_v3 || !i_out_stall;
        rdy2 = !r_v2 || rdy3;
        rdy1 = !r_v1 || rdy2;
        // a character that closes no string never waits on later stages
        adv0 = r_v0 && (!r_s0.last_char || rdy1);
        rdy0 = !r_v0 || adv0;
    end

    assign o_in_stall  = !rdy0;
    assign o_out_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_codes  <= '0;
            r_pattern_length <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                pdtp_pkg::C_REG_PATTERN_CODES:  r_pattern_codes  <= i_cfg_wdata;
                pdtp_pkg::C_REG_PATTERN_LENGTH: r_pattern_length <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy0) begin
                r_v0 <= i_in_valid;
            end
            if (rdy1) begin
                r_v1 <= adv0 && r_s0.last_char;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy0) begin
            r_s0 <= i_in_data;
        end
        if (adv0 && r_s0.last_char) begin
            r_s1 <= parse_fields;
        end
    end

    pdtp_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (adv0),
        .i_char   (r_s0.char_code),
        .i_last   (r_s0.last_char),
        .i_codes  (r_pattern_codes),
        .i_length (r_pattern_length),
        .o_fields (parse_fields)
    );

    pdtp_calendar u_calendar (
        .i_clk     (i_clk),
        .i_load_s2 (r_v1 && rdy2),
        .i_load_s3 (r_v2 && rdy3),
        .i_fields  (r_s1),
        .o_item    (o_out_data)
    );

endmodule

// File: src/pdtp_checker.sv
// ----------------------------------------------------------------------------
// pdtp_checker
// Port-level checks on the date/time parser's result transactions.
// ----------------------------------------------------------------------------
module pdtp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input pdtp_pkg::t_out_item o_out_data
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_valid_needs_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.date_time_valid |-> o_out_data.pattern_matched)
        else $error("valid date reported without a match");

    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.pattern_matched |->
            o_out_data.year_value == 14'd0 && o_out_data.month_value == 7'd0 &&
            o_out_data.day_value == 7'd0 && o_out_data.hour_value == 7'd0 &&
            o_out_data.minute_value == 7'd0 && o_out_data.second_value == 7'd0)
        else $error("unmatched result carries field values");

    a_valid_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.date_time_valid |->
            o_out_data.month_value >= 7'd1 && o_out_data.month_value <= 7'd12 &&
            o_out_data.day_value >= 7'd1 && o_out_data.day_value <= 7'd31 &&
            o_out_data.hour_value < 7'd24 && o_out_data.year_value != 14'd0)
        else $error("valid date outside calendar range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result presented straight after reset");

endmodule

bind pattern_date_time_parser_top pdtp_checker u_checker (.*);

// File: tb/pattern_date_time_parser_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pattern_date_time_parser_top_tb
// Self-checking bench for the pattern-driven date/time string parser. Strings
// built from each configured pattern are streamed one character per
// transaction. Corrupted, truncated and noise strings are mixed in, and both
// sides idle and stall at random. A built-in parser predicts every result and
// a monitor compares it field by field.
// ----------------------------------------------------------------------------
module pattern_date_time_parser_top_tb;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          RANDOM_PHASES   = 13;
    localparam int          ITEMS_PER_PHASE = 100;
    localparam int          PRESSURE_PHASE  = 4;
    localparam int unsigned HOLD_CYCLES     = 400;
    localparam int          PRINT_CAP       = 100;
    localparam logic [7:0]  DIGIT_ZERO      = 8'd48;
    localparam logic [7:0]  DIGIT_NINE      = 8'd57;
    // unused code value, parsed as a one-character skip
    localparam logic [3:0]  CODE_SPARE      = 4'd15;

    logic                i_clk;
    logic                i_rst_n     = 1'b0;
    logic                i_in_valid  = 1'b0;
    logic                o_in_stall;
    pdtp_pkg::t_in_item  i_in_data   = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    pdtp_pkg::t_out_item o_out_data;
    logic                i_cfg_wr_en = 1'b0;
    logic [0:0]          i_cfg_index = '0;
    logic [63:0]         i_cfg_wdata = '0;

    pattern_date_time_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    pdtp_pkg::t_in_item  char_queue[$];
    pdtp_pkg::t_out_item expected_dates[$];
    logic [7:0]          text_buf[$];
    logic [3:0]          plan[$];
    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned hold_left      = 0;
    int unsigned hold_asked     = 0;
    int unsigned hold_given     = 0;
    bit          char_taken     = 1'b0;

    // Mirror of the configuration registers
    logic [63:0] cfg_codes = '0;
    logic [4:0]  cfg_len   = '0;

    // Parse state of the predictor
    logic [4:0]  scan_idx;
    logic [2:0]  scan_digits;
    logic [13:0] scan_acc;
    logic        scan_bad;
    logic        scan_failed;
    logic [13:0] got_year;
    logic [6:0]  got_month, got_day, got_hour, got_minute, got_second;

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic logic [4:0] active_len();
        return (cfg_len > pdtp_pkg::C_MAX_LEN) ? pdtp_pkg::C_MAX_LEN : cfg_len;
    endfunction

    function automatic logic [3:0] code_of(logic [4:0] i);
        return cfg_codes[i[3:0]*4 +: 4];
    endfunction

    function automatic bit is_field(logic [3:0] code);
        return code >= pdtp_pkg::C_CODE_YY && code <= pdtp_pkg::C_CODE_SECOND;
    endfunction

    function automatic bit is_flex(logic [3:0] code);
        return code == pdtp_pkg::C_CODE_MONTH_FLEX || code == pdtp_pkg::C_CODE_DAY_FLEX;
    endfunction

    function automatic void clear_scan();
        scan_idx    = '0;
        scan_digits = '0;
        scan_acc    = '0;
        scan_bad    = 1'b0;
        scan_failed = 1'b0;
        got_year    = '0;
        got_month   = '0;
        got_day     = '0;
        got_hour    = '0;
        got_minute  = '0;
        got_second  = '0;
    endfunction

    function automatic void commit_field(logic [3:0] code);
        logic [13:0] v;
        v = scan_bad ? 14'd0 : scan_acc;
        case (code)
            pdtp_pkg::C_CODE_YY:     got_year   = pdtp_pkg::C_YEAR_BASE + v;
            pdtp_pkg::C_CODE_YYYY:   got_year   = v;
            pdtp_pkg::C_CODE_MONTH_FLEX,
            pdtp_pkg::C_CODE_MONTH:  got_month  = v[6:0];
            pdtp_pkg::C_CODE_DAY_FLEX,
            pdtp_pkg::C_CODE_DAY:    got_day    = v[6:0];
            pdtp_pkg::C_CODE_HOUR:   got_hour   = v[6:0];
            pdtp_pkg::C_CODE_MINUTE: got_minute = v[6:0];
            pdtp_pkg::C_CODE_SECOND: got_second = v[6:0];
            default: ;
        endcase
        scan_acc    = '0;
        scan_bad    = 1'b0;
        scan_digits = '0;
        scan_idx    = scan_idx + 5'd1;
    endfunction

    function automatic void parse_char(logic [7:0] ch);
        logic       digit;
        logic [3:0] dv;
        logic [3:0] code;
        bit         done;
        int         pass;
        digit = ch >= DIGIT_ZERO && ch <= DIGIT_NINE;
        dv    = digit ? 4'(ch - DIGIT_ZERO) : 4'd0;
        done  = 1'b0;
        // a flexible field ended by a non-digit hands that character on
        for (pass = 0; pass < 2 && !done; pass++) begin
            done = 1'b1;
            if (!scan_failed && scan_idx < active_len()) begin
                code = code_of(scan_idx);
                if (!is_field(code)) begin
                    scan_idx = scan_idx + 5'd1;
                end else if (is_flex(code)) begin
                    if (scan_digits == 3'd0) begin
                        if (digit) begin
                            scan_acc    = 14'(dv);
                            scan_digits = 3'd1;
                        end else begin
                            scan_failed = 1'b1;
                        end
                    end else if (digit) begin
                        scan_acc = scan_acc * 14'd10 + 14'(dv);
                        commit_field(code);
                    end else begin
                        commit_field(code);
                        done = 1'b0;
                    end
                end else begin
                    if (digit)
                        scan_acc = scan_acc * 14'd10 + 14'(dv);
                    else
                        scan_bad = 1'b1;
                    scan_digits = scan_digits + 3'd1;
                    if (scan_digits >= ((code == pdtp_pkg::C_CODE_YYYY) ? 3'd4 : 3'd2))
                        commit_field(code);
                end
            end
        end
    endfunction

    function automatic bit close_string();
        logic [3:0] code;
        int         i;
        bit         ok;
        if (scan_failed)
            return 1'b0;
        if (scan_idx < active_len()) begin
            code = code_of(scan_idx);
            if (is_flex(code) && scan_digits == 3'd1)
                commit_field(code);
        end
        ok = 1'b1;
        // skips left over are fine, a pending field is not
        for (i = int'(scan_idx); i < int'(active_len()); i++) begin
            if (is_field(code_of(5'(i))))
                ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic logic [4:0] month_length(logic [6:0] m, logic [13:0] y);
        logic leap;
        leap = (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
        case (m)
            7'd2:                                        return leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:                     return 5'd30;
            7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: return 5'd31;
            default:                                     return 5'd0;
        endcase
    endfunction

    function automatic void predict_date(pdtp_pkg::t_in_item item);
        pdtp_pkg::t_out_item r;
        logic [4:0]          dim;
        bit                  matched;
        parse_char(item.char_code);
        if (item.last_char) begin
            matched = close_string();
            r = '0;
            if (matched) begin
                dim = month_length(got_month, got_year);
                r.year_value      = got_year;
                r.month_value     = got_month;
                r.day_value       = got_day;
                r.hour_value      = got_hour;
                r.minute_value    = got_minute;
                r.second_value    = got_second;
                r.date_time_valid = got_year != 0 && dim != 0 && got_day >= 1
                                    && got_day <= 7'(dim) && got_hour < 24
                                    && got_minute < 60 && got_second < 60;
            end
            r.pattern_matched = matched;
            expected_dates.push_back(r);
            clear_scan();
        end
    endfunction

    initial clear_scan();

    // ------------------------------------------------------------------
    // Input driver: sample acceptance on the rising edge, advance on the falling
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        char_taken = i_rst_n && i_in_valid && o_in_stall === 1'b0;
        if (char_taken)
            predict_date(i_in_data);
    end

    always @(negedge i_clk) begin
        if (!i_in_valid || char_taken) begin
            if (char_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_in_data  <= char_queue.pop_front();
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold-off, counted here and requested by the sequence
    always @(negedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_given != hold_asked) begin
            hold_left  <= HOLD_CYCLES;
            hold_given <= hold_given + 1;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        if (mismatch_count < PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        mismatch_count++;
    endtask

    task automatic check_field(string name, logic [13:0] got, logic [13:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d, want %0d", name, got, want));
    endtask

    always @(posedge i_clk) begin
        pdtp_pkg::t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (expected_dates.size() == 0) begin
                report_mismatch("result transaction with nothing pending");
            end else begin
                want = expected_dates.pop_front();
                check_field("year",    o_out_data.year_value, want.year_value);
                check_field("month",   14'(o_out_data.month_value),
                            14'(want.month_value));
                check_field("day",     14'(o_out_data.day_value), 14'(want.day_value));
                check_field("hour",    14'(o_out_data.hour_value), 14'(want.hour_value));
                check_field("minute",  14'(o_out_data.minute_value),
                            14'(want.minute_value));
                check_field("second",  14'(o_out_data.second_value),
                            14'(want.second_value));
                check_field("matched", 14'(o_out_data.pattern_matched),
                            14'(want.pattern_matched));
                check_field("valid",   14'(o_out_data.date_time_valid),
                            14'(want.date_time_valid));
            end
        end
    end

    // ------------------------------------------------------------------
    // String generation
    // ------------------------------------------------------------------
    function automatic int flush_text();
        pdtp_pkg::t_in_item item;
        int                 i;
        for (i = 0; i < text_buf.size(); i++) begin
            item.char_code = text_buf[i];
            item.last_char = (i == text_buf.size() - 1);
            char_queue.push_back(item);
        end
        return text_buf.size();
    endfunction

    function automatic void queue_text(string s);
        int i;
        text_buf.delete();
        for (i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
        void'(flush_text());
    endfunction

    function automatic logic [7:0] random_byte();
        return 8'($urandom_range(255));
    endfunction

    function automatic logic [7:0] sep_char();
        case ($urandom_range(7))
            0:       return "-";
            1:       return "/";
            2:       return ":";
            3:       return " ";
            4:       return ".";
            5:       return "T";
            default: return random_byte();
        endcase
    endfunction

    // mostly in calendar range, now and then anything two digits can hold
    function automatic int unsigned pick_value(int unsigned lo, int unsigned hi);
        return ($urandom_range(99) < 85) ? $urandom_range(hi, lo) : $urandom_range(99);
    endfunction

    function automatic int unsigned pick_year();
        case ($urandom_range(9))
            0: begin
                case ($urandom_range(7))
                    0:       return 0;
                    1:       return 1600;
                    2:       return 1900;
                    3:       return 2000;
                    4:       return 2100;
                    5:       return 2400;
                    6:       return 9999;
                    default: return 1;
                endcase
            end
            1:       return $urandom_range(9999);
            default: return $urandom_range(2100, 1900);
        endcase
    endfunction

    function automatic void put_number(int unsigned value, int width);
        int unsigned div;
        int          k;
        logic [7:0]  ch;
        div = (width == 4) ? 1000 : 10;
        for (k = 0; k < width; k++) begin
            ch  = DIGIT_ZERO + 8'((value / div) % 10);
            div = div / 10;
            if ($urandom_range(99) < 4)
                ch = random_byte();
            text_buf.push_back(ch);
        end
    endfunction

    function automatic void put_flex(int unsigned value);
        if ($urandom_range(99) < 3)
            text_buf.push_back(random_byte());
        else if (value < 10 && $urandom_range(1) == 1)
            text_buf.push_back(DIGIT_ZERO + 8'(value));
        else
            put_number(value, 2);
    endfunction

    function automatic int queue_random_string();
        int          i;
        int unsigned kind;
        int unsigned cut;
        text_buf.delete();
        kind = $urandom_range(99);
        if (kind < 90) begin
            for (i = 0; i < int'(active_len()); i++) begin
                case (code_of(5'(i)))
                    pdtp_pkg::C_CODE_YY:         put_number(pick_value(0, 99), 2);
                    pdtp_pkg::C_CODE_YYYY:       put_number(pick_year(), 4);
                    pdtp_pkg::C_CODE_MONTH_FLEX: put_flex(pick_value(1, 12));
                    pdtp_pkg::C_CODE_MONTH:      put_number(pick_value(1, 12), 2);
                    pdtp_pkg::C_CODE_DAY_FLEX:   put_flex(pick_value(1, 31));
                    pdtp_pkg::C_CODE_DAY:        put_number(pick_value(1, 31), 2);
                    pdtp_pkg::C_CODE_HOUR:       put_number(pick_value(0, 23), 2);
                    pdtp_pkg::C_CODE_MINUTE:     put_number(pick_value(0, 59), 2);
                    pdtp_pkg::C_CODE_SECOND:     put_number(pick_value(0, 59), 2);
                    default:                     text_buf.push_back(sep_char());
                endcase
            end
            if (kind >= 70 && kind < 80) begin
                repeat ($urandom_range(4, 1)) text_buf.push_back(random_byte());
            end else if (kind >= 80 && text_buf.size() > 1) begin
                cut = $urandom_range(text_buf.size() - 1, 1);
                while (text_buf.size() > cut)
                    void'(text_buf.pop_back());
            end
        end else begin
            repeat ($urandom_range(12, 1)) text_buf.push_back(random_byte());
        end
        if (text_buf.size() == 0)
            text_buf.push_back(random_byte());
        return flush_text();
    endfunction

    // ------------------------------------------------------------------
    // Configuration and sequencing
    // ------------------------------------------------------------------
    task automatic write_reg(logic [0:0] idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        if (idx == pdtp_pkg::C_REG_PATTERN_CODES)
            cfg_codes = value;
        else
            cfg_len = value[4:0];
    endtask

    function automatic logic [63:0] pack_plan();
        logic [63:0] word;
        word = '0;
        foreach (plan[i]) begin
            if (i < pdtp_pkg::C_MAX_CODES)
                word[i*4 +: 4] = plan[i];
        end
        return word;
    endfunction

    task automatic load_pattern(int sel);
        logic [63:0] codes_word;
        logic [63:0] len_word;
        case (sel)
            0: plan = '{pdtp_pkg::C_CODE_YYYY, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_MONTH, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_DAY, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_HOUR, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_MINUTE, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_SECOND};
            1: plan = '{pdtp_pkg::C_CODE_MONTH_FLEX, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_DAY_FLEX, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_YYYY};
            2: plan = '{pdtp_pkg::C_CODE_DAY_FLEX, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_MONTH_FLEX, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_YY};
            3: plan = '{pdtp_pkg::C_CODE_YY, pdtp_pkg::C_CODE_MONTH,
                        pdtp_pkg::C_CODE_DAY, pdtp_pkg::C_CODE_HOUR,
                        pdtp_pkg::C_CODE_MINUTE, pdtp_pkg::C_CODE_SECOND};
            4: plan = '{pdtp_pkg::C_CODE_YYYY, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_MONTH_FLEX, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_DAY_FLEX, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_HOUR, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_MINUTE, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_SECOND, pdtp_pkg::C_CODE_SKIP,
                        CODE_SPARE, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_SKIP, pdtp_pkg::C_CODE_SKIP};
            6: plan = '{pdtp_pkg::C_CODE_DAY, CODE_SPARE,
                        pdtp_pkg::C_CODE_MONTH, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_YYYY, pdtp_pkg::C_CODE_SKIP,
                        pdtp_pkg::C_CODE_HOUR, pdtp_pkg::C_CODE_MINUTE};
            default: plan = '{pdtp_pkg::C_CODE_HOUR, pdtp_pkg::C_CODE_MINUTE};
        endcase
        codes_word = pack_plan();
        len_word   = 64'(plan.size());
        if (sel == 5) begin
            codes_word = {$urandom, $urandom};
            len_word   = {$urandom, $urandom};
        end else if (sel == 6) begin
            // one trailing skip beyond the listed codes
            len_word = len_word + 64'd1;
        end else if (sel == 7) begin
            // all spare codes and a length that saturates
            codes_word = '1;
            len_word   = '1;
        end
        write_reg(pdtp_pkg::C_REG_PATTERN_CODES, codes_word);
        write_reg(pdtp_pkg::C_REG_PATTERN_LENGTH, len_word);
    endtask

    task automatic set_idling(int mode);
        case (mode)
            1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
            3: begin send_idle_pct = 26; recv_stall_pct = 26; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
        endcase
    endtask

    // hold until every queued character is taken and every result is back
    task automatic drain();
        while (char_queue.size() != 0 || i_in_valid || expected_dates.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int phase;
        int count;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Empty pattern after reset: anything matches, year zero is invalid
        char_queue.push_back(pdtp_pkg::t_in_item'{char_code: 8'hFF, last_char: 1'b1});
        drain();

        // Flexible month ended by a separator, 1900-based year, failed and short strings
        plan = '{pdtp_pkg::C_CODE_MONTH_FLEX, pdtp_pkg::C_CODE_SKIP, pdtp_pkg::C_CODE_DAY,
                 pdtp_pkg::C_CODE_SKIP, pdtp_pkg::C_CODE_YY};
        write_reg(pdtp_pkg::C_REG_PATTERN_CODES, pack_plan());
        write_reg(pdtp_pkg::C_REG_PATTERN_LENGTH, 64'(plan.size()));
        queue_text("2/29/00");
        queue_text("x");
        queue_text("12/3");
        drain();

        // Leap day, non-digit in a fixed field, saturated length with trailing skips
        plan = '{pdtp_pkg::C_CODE_YYYY, pdtp_pkg::C_CODE_MONTH, pdtp_pkg::C_CODE_DAY_FLEX,
                 pdtp_pkg::C_CODE_HOUR, pdtp_pkg::C_CODE_MINUTE, pdtp_pkg::C_CODE_SECOND,
                 CODE_SPARE};
        write_reg(pdtp_pkg::C_REG_PATTERN_CODES, pack_plan());
        write_reg(pdtp_pkg::C_REG_PATTERN_LENGTH, '1);
        queue_text("20000229235a59");
        drain();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            load_pattern((phase == PRESSURE_PHASE) ? 8 : phase % 8);
            set_idling(phase % 4);
            if (phase == PRESSURE_PHASE)
                hold_asked++;
            count = 0;
            while (count < ITEMS_PER_PHASE)
                count += queue_random_string();
            drain();
        end

        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
src/pdtp_pkg.sv
src/pdtp_parse.sv
src/pdtp_calendar.sv
src/pattern_date_time_parser_top.sv
src/pdtp_checker.sv
tb/pattern_date_time_parser_top_tb.sv
